@@ hdl/oahm_pkg.sv @@
// Package for the open-addressing hash map: constants, codes and types.
// Used by every module of the block; depends on nothing.
package oahm_pkg;

    localparam int LOG_SLOTS_DEFAULT = 6;
    localparam int MOD_W = 7;
    localparam logic [MOD_W-1:0] MODULUS_RESET = 7'd61;
    localparam int KEY_W = 32;
    localparam int VAL_W = 32;

    typedef enum logic [1:0] {
        KIND_GET = 2'd0,
        KIND_PUT = 2'd1,
        KIND_DEL = 2'd2,
        KIND_CLR = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        MARK_UNUSED = 2'd0,
        MARK_TOMB   = 2'd1,
        MARK_FULL   = 2'd2,
        MARK_BAD    = 2'd3
    } mark_t;

    typedef enum logic [2:0] {
        ST_FOUND     = 3'd0,
        ST_NOT_FOUND = 3'd1,
        ST_INSERTED  = 3'd2,
        ST_REPLACED  = 3'd3,
        ST_DELETED   = 3'd4,
        ST_FULL      = 3'd5,
        ST_CLEARED   = 3'd6
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CLEAR,
        S_MOD,
        S_READ,
        S_CHECK,
        S_WRITE,
        S_OUT
    } state_t;

endpackage

@@ hdl/oahm_modulo.sv @@
// Iterative restoring remainder of a 32-bit key by the 7-bit modulus register.
// Depends on oahm_pkg.
module oahm_modulo (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [oahm_pkg::KEY_W-1:0]    key,
    input  logic [oahm_pkg::MOD_W-1:0]    modulus,
    output logic                          done,
    output logic [oahm_pkg::MOD_W-1:0]    rem
);
    import oahm_pkg::*;

    logic [KEY_W-1:0] key_reg;
    logic [MOD_W:0]   rem_reg;
    logic [MOD_W-1:0] div_reg;
    logic [5:0]       cnt_reg;
    logic             busy_reg;
    logic [MOD_W:0]   trial;

    assign trial = {rem_reg[MOD_W-1:0], key_reg[KEY_W-1]};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done     <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                key_reg  <= key;
                rem_reg  <= '0;
                div_reg  <= (modulus == '0) ? MOD_W'(1) : modulus;
                cnt_reg  <= 6'(KEY_W);
            end else if (busy_reg) begin
                key_reg <= {key_reg[KEY_W-2:0], 1'b0};
                if (trial >= {1'b0, div_reg}) begin
                    rem_reg <= trial - {1'b0, div_reg};
                end else begin
                    rem_reg <= trial;
                end
                cnt_reg <= cnt_reg - 6'd1;
                if (cnt_reg == 6'd1) begin
                    busy_reg <= 1'b0;
                    done     <= 1'b1;
                end
            end
        end
    end

    assign rem = rem_reg[MOD_W-1:0];

endmodule

@@ hdl/oahm_store.sv @@
// Slot store: one synchronous memory of mark, key and value per slot.
// Depends on oahm_pkg.
module oahm_store #(
    parameter int LOG_SLOTS = oahm_pkg::LOG_SLOTS_DEFAULT
) (
    input  logic                                    aclk,
    input  logic [LOG_SLOTS-1:0]                    rd_addr,
    output logic [2+2*oahm_pkg::KEY_W-1:0]          rd_data,
    input  logic                                    wr_en,
    input  logic [LOG_SLOTS-1:0]                    wr_addr,
    input  logic [2+2*oahm_pkg::KEY_W-1:0]          wr_data
);
    import oahm_pkg::*;

    logic [2+2*KEY_W-1:0] mem [2**LOG_SLOTS];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

@@ hdl/open_addressing_hash_map.sv @@
// Open-addressing hash map with triangular probing over 2**LOG_SLOTS slots.
// The home slot is the key's remainder by mod_reg from an iterative divide; each
// probed slot is then read and checked, and a write step comes before the result;
// a clear writes every slot. One item is worked at a time, and the next item is
// accepted in the cycle after the result is taken. After reset a clearing pass over
// all 2**LOG_SLOTS slots runs before the first item; reset also sets mod_reg to 61.
module open_addressing_hash_map #(
    parameter int LOG_SLOTS = oahm_pkg::LOG_SLOTS_DEFAULT
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_we,
    input  logic [oahm_pkg::MOD_W-1:0]  cfg_wdata,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [71:0]                 s_tdata,  // kind[1:0], key[33:2], value[65:34]
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [39:0]                 m_tdata   // status[2:0], value_out[34:3]
);
    import oahm_pkg::*;

    localparam int SLOTS = 2**LOG_SLOTS;
    localparam int ENT_W = 2 + 2*KEY_W;

    state_t state_reg, state_next;
    logic [MOD_W-1:0]     mod_reg;
    kind_t                kind_reg;
    logic [KEY_W-1:0]     key_reg;
    logic [VAL_W-1:0]     val_reg;
    logic [LOG_SLOTS-1:0] idx_reg;
    logic [LOG_SLOTS:0]   step_reg;
    logic [LOG_SLOTS:0]   n_reg;
    logic                 tomb_reg;
    logic [LOG_SLOTS-1:0] tomb_at_reg;
    logic                 hit_reg;
    logic                 have_reg;
    logic [LOG_SLOTS-1:0] where_reg;
    logic [VAL_W-1:0]     hitval_reg;
    logic [2:0]           st_reg;
    logic [VAL_W-1:0]     vout_reg;
    logic [LOG_SLOTS:0]   clr_reg;

    logic                 mod_start, mod_done;
    logic [MOD_W-1:0]     mod_rem;
    logic [ENT_W-1:0]     rd_data, wr_data;
    logic                 wr_en;
    logic [LOG_SLOTS-1:0] wr_addr;
    mark_t                rd_mark;
    logic [KEY_W-1:0]     rd_key;
    logic [VAL_W-1:0]     rd_val;
    logic                 last_probe;

    assign rd_mark = mark_t'(rd_data[1:0]);
    assign rd_key  = rd_data[2+:KEY_W];
    assign rd_val  = rd_data[2+KEY_W+:VAL_W];

    oahm_modulo u_mod (
        .aclk(aclk), .aresetn(aresetn), .start(mod_start), .key(s_tdata[2+:KEY_W]),
        .modulus(mod_reg), .done(mod_done), .rem(mod_rem)
    );

    oahm_store #(.LOG_SLOTS(LOG_SLOTS)) u_store (
        .aclk(aclk), .rd_addr(idx_reg), .rd_data(rd_data),
        .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data)
    );

    assign last_probe = (n_reg == (LOG_SLOTS+1)'(SLOTS - 1));

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    state_next = (kind_t'(s_tdata[1:0]) == KIND_CLR) ? S_CLEAR : S_MOD;
                end
            end
            S_CLEAR: begin
                if (clr_reg == (LOG_SLOTS+1)'(SLOTS - 1)) begin
                    state_next = (kind_reg == KIND_CLR) ? S_OUT : S_IDLE;
                end
            end
            S_MOD:   if (mod_done) state_next = S_READ;
            S_READ:  state_next = S_CHECK;
            S_CHECK: begin
                if (rd_mark == MARK_UNUSED || (rd_mark == MARK_FULL && rd_key == key_reg)
                        || last_probe) begin
                    state_next = S_WRITE;
                end else begin
                    state_next = S_READ;
                end
            end
            S_WRITE: state_next = S_OUT;
            S_OUT:   if (m_tready) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        s_tready  = (state_reg == S_IDLE);
        m_tvalid  = (state_reg == S_OUT);
        m_tdata   = {5'd0, vout_reg, st_reg};
        mod_start = (state_reg == S_IDLE) && s_tvalid
                    && (kind_t'(s_tdata[1:0]) != KIND_CLR);
        wr_en     = 1'b0;
        wr_addr   = where_reg;
        wr_data   = '0;
        if (state_reg == S_CLEAR) begin
            wr_en   = 1'b1;
            wr_addr = clr_reg[LOG_SLOTS-1:0];
        end else if (state_reg == S_WRITE) begin
            priority if (kind_reg == KIND_PUT && hit_reg) begin
                wr_en   = 1'b1;
                wr_data = {val_reg, key_reg, MARK_FULL};
            end else if (kind_reg == KIND_PUT && have_reg) begin
                wr_en   = 1'b1;
                wr_data = {val_reg, key_reg, MARK_FULL};
            end else if (kind_reg == KIND_DEL && hit_reg) begin
                wr_en   = 1'b1;
                wr_data = {{VAL_W{1'b0}}, {KEY_W{1'b0}}, MARK_TOMB};
            end else begin
                wr_en   = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
            mod_reg   <= MODULUS_RESET;
            clr_reg   <= '0;
            kind_reg  <= KIND_GET;
        end else begin
            state_reg <= state_next;
            if (cfg_we) mod_reg <= cfg_wdata;
            unique case (state_reg)
                S_IDLE: begin
                    if (s_tvalid) begin
                        kind_reg <= kind_t'(s_tdata[1:0]);
                        key_reg  <= s_tdata[2+:KEY_W];
                        val_reg  <= s_tdata[2+KEY_W+:VAL_W];
                        clr_reg  <= '0;
                    end
                end
                S_CLEAR: begin
                    clr_reg  <= clr_reg + 1'b1;
                    st_reg   <= ST_CLEARED;
                    vout_reg <= '0;
                end
                S_MOD: begin
                    idx_reg  <= LOG_SLOTS'(mod_rem);
                    step_reg <= '0;
                    n_reg    <= '0;
                    tomb_reg <= 1'b0;
                end
                S_READ: ;
                S_CHECK: begin
                    hit_reg <= 1'b0;
                    if (rd_mark == MARK_UNUSED) begin
                        have_reg  <= 1'b1;
                        where_reg <= tomb_reg ? tomb_at_reg : idx_reg;
                    end else if (rd_mark == MARK_FULL && rd_key == key_reg) begin
                        hit_reg    <= 1'b1;
                        where_reg  <= idx_reg;
                        hitval_reg <= rd_val;
                    end else begin
                        if (rd_mark == MARK_TOMB && !tomb_reg) begin
                            tomb_reg    <= 1'b1;
                            tomb_at_reg <= idx_reg;
                        end
                        have_reg  <= tomb_reg || (rd_mark == MARK_TOMB);
                        where_reg <= tomb_reg ? tomb_at_reg : idx_reg;
                        idx_reg   <= idx_reg + step_reg[LOG_SLOTS-1:0] + 1'b1;
                        step_reg  <= step_reg + 1'b1;
                        n_reg     <= n_reg + 1'b1;
                    end
                end
                S_WRITE: begin
                    vout_reg <= '0;
                    unique case (kind_reg)
                        KIND_GET: begin
                            st_reg <= hit_reg ? ST_FOUND : ST_NOT_FOUND;
                            if (hit_reg) vout_reg <= hitval_reg;
                        end
                        KIND_PUT: st_reg <= hit_reg ? ST_REPLACED :
                                            (have_reg ? ST_INSERTED : ST_FULL);
                        KIND_DEL: st_reg <= hit_reg ? ST_DELETED : ST_NOT_FOUND;
                        default:  st_reg <= ST_CLEARED;
                    endcase
                end
                S_OUT: ;
                default: ;
            endcase
        end
    end

endmodule
